>>> design/lpbc_pkg.sv
`timescale 1ns / 1ps

package lpbc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam int OP_W    = 3;
    localparam int OWNER_W = 2;
    localparam int ADDR_W  = 31;
    localparam int SLOT_W  = 3;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_NEW    = 3'd1;
    localparam logic [OP_W-1:0] OP_DIRTY  = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        logic               hit;
        logic               need_read;
        logic               write_back;
        logic [OWNER_W-1:0] wb_owner;
        logic [ADDR_W-1:0]  wb_addr;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic lookup;
        logic exec;
        logic flush_step;
    } cmd_t;

    typedef struct packed {
        logic flush_any;
        logic flush_last;
        logic out_free;
    } sts_t;

endpackage

>>> design/lpbc_if.sv
`timescale 1ns / 1ps

interface lpbc_req_if;
    logic                        valid;
    logic                        ready;
    logic [lpbc_pkg::OP_W-1:0]    op;
    logic [lpbc_pkg::OWNER_W-1:0] owner;
    logic [lpbc_pkg::ADDR_W-1:0]  page_addr;
    logic [lpbc_pkg::SLOT_W-1:0]  slot_in;

    modport source (output valid, op, owner, page_addr, slot_in, input ready);
    modport sink (input valid, op, owner, page_addr, slot_in, output ready);
endinterface

interface lpbc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lpbc_pkg::SLOT_W-1:0]  slot_out;
    logic                        hit;
    logic                        need_read;
    logic                        write_back;
    logic [lpbc_pkg::OWNER_W-1:0] wb_owner;
    logic [lpbc_pkg::ADDR_W-1:0]  wb_addr;
    logic                        last;

    modport source (output valid, slot_out, hit, need_read, write_back, wb_owner, wb_addr,
                    last, input ready);
    modport sink (input valid, slot_out, hit, need_read, write_back, wb_owner, wb_addr,
                  last, output ready);
endinterface

>>> design/lru_page_buffer_cache_top.sv
`timescale 1ns / 1ps
// Page buffer tag and replacement controller with strict LRU order and dirty bits.
// Requests arrive on req (op, owner, page_addr, slot_in); results leave on rsp,
// each with slot_out, hit, need_read, write_back, wb_owner, wb_addr and last.
// Both channels move an item when valid and ready are high at a rising edge.
// Every request gives at least one result item; a flush gives one item per dirty
// entry of its owner, and the final item of a request carries last.
// A request is taken in the idle state and looked up against all slots in the
// lookup state; its result, or each flush item in turn, is then loaded into the
// output register once that register is free. The LRU list and the tag store are
// updated at that point, so the next request is taken in the cycle after.
// The output register holds a result while the receiver stalls; the block still
// takes a new request then, but will not overwrite a result that has not gone.
// Reset empties all slots, clears the dirty bits and sets the LRU list to slot
// order, lowest slot least recently used; no sweep is needed after reset.

module lru_page_buffer_cache_top (
    input  logic        clk,
    input  logic        rst_n,
    lpbc_req_if.sink    req,
    lpbc_rsp_if.source  rsp
);

    lpbc_pkg::cmd_t cmd;
    lpbc_pkg::sts_t sts;
    logic           req_ready;

    assign req.ready = req_ready;

    lpbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpbc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (req.op),
        .owner     (req.owner),
        .page_addr (req.page_addr),
        .slot_in   (req.slot_in),
        .rsp       (rsp)
    );

endmodule

>>> design/lpbc_ctrl.sv
`timescale 1ns / 1ps

module lpbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpbc_pkg::sts_t      sts,
    output lpbc_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = sts.flush_any ? ST_FLUSH : ST_EXEC;
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush_step = 1'b1;
                    if (sts.flush_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/lpbc_datapath.sv
`timescale 1ns / 1ps

module lpbc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpbc_pkg::cmd_t                cmd,
    output lpbc_pkg::sts_t                sts,
    input  logic [lpbc_pkg::OP_W-1:0]      op,
    input  logic [lpbc_pkg::OWNER_W-1:0]   owner,
    input  logic [lpbc_pkg::ADDR_W-1:0]    page_addr,
    input  logic [lpbc_pkg::SLOT_W-1:0]    slot_in,
    lpbc_rsp_if.source                    rsp
);

    localparam int N = lpbc_pkg::ENTRIES;
    localparam int W = lpbc_pkg::IDX_W;

    // Request captured at acceptance.
    logic [lpbc_pkg::OP_W-1:0]    op_reg;
    logic [lpbc_pkg::OWNER_W-1:0] owner_reg;
    logic [lpbc_pkg::ADDR_W-1:0]  addr_reg;
    logic [lpbc_pkg::SLOT_W-1:0]  slot_reg;

    // Tag store and recency list.
    logic [N-1:0]                        valid_reg, valid_next;
    logic [N-1:0]                        dirty_reg, dirty_next;
    logic [lpbc_pkg::OWNER_W-1:0]        eowner_reg [N];
    logic [lpbc_pkg::OWNER_W-1:0]        eowner_next [N];
    logic [lpbc_pkg::ADDR_W-1:0]         eaddr_reg [N];
    logic [lpbc_pkg::ADDR_W-1:0]         eaddr_next [N];
    logic [W-1:0]                        lru_reg [N];
    logic [W-1:0]                        lru_next [N];

    // Lookup results.
    logic         hit_reg;
    logic [W-1:0] hit_idx_reg;
    logic [W-1:0] victim_reg;
    logic [N-1:0] fmask_reg, fmask_next;

    // Output register.
    logic           out_valid_reg, out_valid_next;
    lpbc_pkg::rsp_t out_reg, out_next;

    logic [N-1:0] match_vec;
    logic [N-1:0] flush_vec;
    logic         hit_any;
    logic [W-1:0] hit_idx;
    logic [W-1:0] flow_idx;
    logic [N-1:0] fmask_rest;
    logic [W-1:0] mru_slot;
    logic [W-1:0] mru_pos;
    logic         slot_ok;
    logic [W-1:0] slot_idx;
    logic         is_fill;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match_vec[i] = valid_reg[i] && (eowner_reg[i] == owner_reg)
                           && (eaddr_reg[i] == addr_reg);
            flush_vec[i] = valid_reg[i] && dirty_reg[i] && (eowner_reg[i] == owner_reg);
        end
    end

    // Lowest index wins in both encoders.
    always_comb
    begin
        hit_any  = |match_vec;
        hit_idx  = '0;
        flow_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = W'(i);
            end
            if (fmask_reg[i])
            begin
                flow_idx = W'(i);
            end
        end
        fmask_rest = fmask_reg & ~(N'(1) << flow_idx);
    end

    assign slot_ok  = int'(slot_reg) < N;
    assign slot_idx = W'(slot_reg);
    assign is_fill  = (op_reg == lpbc_pkg::OP_GET) || (op_reg == lpbc_pkg::OP_NEW);
    assign mru_slot = (op_reg == lpbc_pkg::OP_GET && hit_reg) ? hit_idx_reg : victim_reg;

    always_comb
    begin
        mru_pos = W'(N - 1);
        for (int k = N - 2; k >= 0; k--)
        begin
            if (lru_reg[k] == mru_slot)
            begin
                mru_pos = W'(k);
            end
        end
    end

    always_comb
    begin
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        eowner_next    = eowner_reg;
        eaddr_next     = eaddr_reg;
        lru_next       = lru_reg;
        fmask_next     = fmask_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.lookup)
        begin
            fmask_next = (op_reg == lpbc_pkg::OP_FLUSH) ? flush_vec : '0;
        end

        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            out_next.last  = 1'b1;
            case (op_reg)
                lpbc_pkg::OP_GET, lpbc_pkg::OP_NEW:
                begin
                    out_next.slot_out = lpbc_pkg::SLOT_W'(mru_slot);
                    if (op_reg == lpbc_pkg::OP_GET && hit_reg)
                    begin
                        out_next.hit = 1'b1;
                    end
                    else
                    begin
                        out_next.need_read = (op_reg == lpbc_pkg::OP_GET);
                        if (dirty_reg[victim_reg])
                        begin
                            out_next.write_back = 1'b1;
                            out_next.wb_owner   = eowner_reg[victim_reg];
                            out_next.wb_addr    = eaddr_reg[victim_reg];
                        end
                        valid_next[victim_reg]  = 1'b1;
                        dirty_next[victim_reg]  = 1'b0;
                        eowner_next[victim_reg] = owner_reg;
                        eaddr_next[victim_reg]  = addr_reg;
                    end
                end
                lpbc_pkg::OP_DIRTY:
                begin
                    out_next.slot_out = slot_reg;
                    if (slot_ok && valid_reg[slot_idx])
                    begin
                        dirty_next[slot_idx] = 1'b1;
                    end
                end
                lpbc_pkg::OP_DELETE:
                begin
                    out_next.slot_out = slot_reg;
                    if (slot_ok)
                    begin
                        valid_next[slot_idx]  = 1'b0;
                        dirty_next[slot_idx]  = 1'b0;
                        eowner_next[slot_idx] = '0;
                        eaddr_next[slot_idx]  = '0;
                    end
                end
                default:
                begin
                    // Flush with nothing to write and undefined codes give a bare final item.
                end
            endcase

            if (is_fill)
            begin
                for (int j = 0; j < N - 1; j++)
                begin
                    if (W'(j) >= mru_pos)
                    begin
                        lru_next[j] = lru_reg[j + 1];
                    end
                end
                lru_next[N - 1] = mru_slot;
            end
        end

        if (cmd.flush_step)
        begin
            out_valid_next      = 1'b1;
            out_next            = '0;
            out_next.slot_out   = lpbc_pkg::SLOT_W'(flow_idx);
            out_next.write_back = 1'b1;
            out_next.wb_owner   = eowner_reg[flow_idx];
            out_next.wb_addr    = eaddr_reg[flow_idx];
            out_next.last       = (fmask_rest == '0);
            dirty_next[flow_idx] = 1'b0;
            fmask_next          = fmask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            fmask_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                lru_reg[i] <= W'(i);
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            fmask_reg     <= fmask_next;
            out_valid_reg <= out_valid_next;
            lru_reg       <= lru_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eowner_reg <= eowner_next;
        eaddr_reg  <= eaddr_next;
        out_reg    <= out_next;
        if (cmd.load_req)
        begin
            op_reg    <= op;
            owner_reg <= owner;
            addr_reg  <= page_addr;
            slot_reg  <= slot_in;
        end
        if (cmd.lookup)
        begin
            hit_reg     <= hit_any;
            hit_idx_reg <= hit_idx;
            victim_reg  <= lru_reg[0];
        end
    end

    assign sts.flush_any  = (op_reg == lpbc_pkg::OP_FLUSH) && (flush_vec != '0);
    assign sts.flush_last = (fmask_rest == '0);
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.slot_out   = out_reg.slot_out;
    assign rsp.hit        = out_reg.hit;
    assign rsp.need_read  = out_reg.need_read;
    assign rsp.write_back = out_reg.write_back;
    assign rsp.wb_owner   = out_reg.wb_owner;
    assign rsp.wb_addr    = out_reg.wb_addr;
    assign rsp.last       = out_reg.last;

endmodule
